// ===== hdl/recursive_mutex_fifo_handoff_macros.svh =====
// Assertion helpers shared by the lock design.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_MACROS_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_MACROS_SVH

// Same-cycle implication.
`define RMFH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RMFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rmfh_pkg.sv =====
package rmfh_pkg;

	// Fixed payload widths
	localparam int OP_W     = 2;
	localparam int TID_W    = 8;
	localparam int STATUS_W = 4;
	localparam int HOLD_W   = 15;

	// Default sizing
	localparam int THREAD_BITS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int COUNT_BITS_DEF  = 15;

	// Request decoding: the high bit selects release, the low bit a try
	localparam int OP_RELEASE_BIT = 1;
	localparam int OP_TRY_BIT     = 0;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEW       = 4'd0,
		ST_REGRANT   = 4'd1,
		ST_QUEUED    = 4'd2,
		ST_REFUSED   = 4'd3,
		ST_HELD      = 4'd4,
		ST_FREED     = 4'd5,
		ST_HANDOVER  = 4'd6,
		ST_WRONG     = 4'd7,
		ST_FULL      = 4'd8,
		ST_SATURATED = 4'd9
	} rmfh_status_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} rmfh_cmd_t;

	typedef struct packed {
		logic out_full;
	} rmfh_stat_t;

endpackage

// ===== hdl/rmfh_req_if.sv =====
interface rmfh_req_if;
	logic                       valid;
	logic                       ready;
	logic [rmfh_pkg::OP_W-1:0]  op;
	logic [rmfh_pkg::TID_W-1:0] thread_id;

	modport source (output valid, output op, output thread_id, input ready);
	modport sink   (input valid, input op, input thread_id, output ready);
endinterface

// ===== hdl/rmfh_rsp_if.sv =====
interface rmfh_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rmfh_pkg::STATUS_W-1:0] status;
	logic [rmfh_pkg::TID_W-1:0]    next_owner;
	logic [rmfh_pkg::HOLD_W-1:0]   hold_count;

	modport source (output valid, output status, output next_owner, output hold_count,
		input ready);
	modport sink   (input valid, input status, input next_owner, input hold_count,
		output ready);
endinterface

// ===== hdl/rmfh_ctrl.sv =====
module rmfh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  rmfh_pkg::rmfh_stat_t stat,
	output rmfh_pkg::rmfh_cmd_t  cmd
);
	import rmfh_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	// decide only when the result register is free or being emptied
	assign cmd.execute = (state_q == S_EXEC) && (!stat.out_full || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.execute) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== hdl/rmfh_dpath.sv =====
`include "recursive_mutex_fifo_handoff_macros.svh"

module rmfh_dpath #(
	parameter int THREAD_BITS = rmfh_pkg::THREAD_BITS_DEF,
	parameter int QUEUE_DEPTH = rmfh_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS  = rmfh_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmfh_pkg::rmfh_cmd_t           cmd,
	output rmfh_pkg::rmfh_stat_t          stat,
	input  logic [rmfh_pkg::OP_W-1:0]     op,
	input  logic [rmfh_pkg::TID_W-1:0]    thread_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rmfh_pkg::STATUS_W-1:0] status,
	output logic [rmfh_pkg::TID_W-1:0]    next_owner,
	output logic [rmfh_pkg::HOLD_W-1:0]   hold_count
);
	import rmfh_pkg::*;

	localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0]   LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [FILL_BITS-1:0]  FILL_MAX  = FILL_BITS'(QUEUE_DEPTH);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// Request registers
	logic [OP_W-1:0]        op_q;
	logic [THREAD_BITS-1:0] tid_q;

	// Lock state
	logic                   owner_valid_q;
	logic [THREAD_BITS-1:0] owner_q;
	logic [COUNT_BITS-1:0]  holds_q;
	logic [PTR_BITS-1:0]    head_q;
	logic [PTR_BITS-1:0]    tail_q;
	logic [FILL_BITS-1:0]   fill_q;

	// Waiter queue
	logic [THREAD_BITS-1:0] queue_mem [QUEUE_DEPTH];
	logic [THREAD_BITS-1:0] head_rd_q;

	// Result register
	logic                   out_valid_q;
	rmfh_status_t           status_q;
	logic [TID_W-1:0]       next_owner_q;
	logic [HOLD_W-1:0]      hold_q;

	// Decision
	logic                   valid_d;
	logic [THREAD_BITS-1:0] owner_d;
	logic [COUNT_BITS-1:0]  holds_d;
	rmfh_status_t           status_d;
	logic [THREAD_BITS-1:0] wake_d;
	logic                   push;
	logic                   pop;

	always_comb begin
		valid_d  = owner_valid_q;
		owner_d  = owner_q;
		holds_d  = holds_q;
		status_d = ST_NEW;
		wake_d   = '0;
		push     = 1'b0;
		pop      = 1'b0;
		if (op_q[OP_RELEASE_BIT]) begin
			if (!owner_valid_q || owner_q != tid_q) begin
				status_d = ST_WRONG;
			end else if (holds_q > COUNT_ONE) begin
				holds_d  = holds_q - COUNT_ONE;
				status_d = ST_HELD;
			end else if (fill_q == '0) begin
				valid_d  = 1'b0;
				owner_d  = '0;
				holds_d  = '0;
				status_d = ST_FREED;
			end else begin
				pop      = 1'b1;
				owner_d  = head_rd_q;
				holds_d  = COUNT_ONE;
				wake_d   = head_rd_q;
				status_d = ST_HANDOVER;
			end
		end else if (!owner_valid_q) begin
			valid_d  = 1'b1;
			owner_d  = tid_q;
			holds_d  = COUNT_ONE;
			status_d = ST_NEW;
		end else if (owner_q == tid_q) begin
			if (holds_q == COUNT_MAX) begin
				status_d = ST_SATURATED;
			end else begin
				holds_d  = holds_q + COUNT_ONE;
				status_d = ST_REGRANT;
			end
		end else if (op_q[OP_TRY_BIT]) begin
			status_d = ST_REFUSED;
		end else if (fill_q >= FILL_MAX) begin
			status_d = ST_FULL;
		end else begin
			push     = 1'b1;
			status_d = ST_QUEUED;
		end
	end

	// Capture the request, fetch the oldest waiter and write a queued waiter
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op;
			tid_q     <= THREAD_BITS'(thread_id);
			head_rd_q <= queue_mem[head_q];
		end
		if (cmd.execute && push) queue_mem[tail_q] <= tid_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q     <= status_d;
			next_owner_q <= TID_W'(wake_d);
			hold_q       <= valid_d ? HOLD_W'(holds_d) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_valid_q <= 1'b0;
			owner_q       <= '0;
			holds_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			fill_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.execute) begin
				owner_valid_q <= valid_d;
				owner_q       <= owner_d;
				holds_q       <= holds_d;
				if (push) begin
					tail_q <= (tail_q == LAST_SLOT) ? '0 : tail_q + PTR_BITS'(1);
					fill_q <= fill_q + FILL_BITS'(1);
				end
				if (pop) begin
					head_q <= (head_q == LAST_SLOT) ? '0 : head_q + PTR_BITS'(1);
					fill_q <= fill_q - FILL_BITS'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_full = out_valid_q;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign next_owner    = next_owner_q;
	assign hold_count    = hold_q;

	`RMFH_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FILL_MAX, "waiter count beyond depth")
	`RMFH_ASSERT_IMPL(a_free_no_holds, !owner_valid_q, holds_q == '0 && owner_q == '0,
		"free lock carries an owner or a count")
	`RMFH_ASSERT_IMPL(a_owner_holds, owner_valid_q, holds_q != '0, "owned lock with zero count")
	`RMFH_ASSERT_NEXT(a_handover_pop, cmd.execute && pop,
		fill_q == $past(fill_q) - FILL_BITS'(1) && holds_q == COUNT_ONE,
		"handover did not take one waiter")

endmodule

// ===== hdl/recursive_mutex_fifo_handoff.sv =====
// Channel | Dir | Payload                                  | Handshake
// req     | in  | op[1:0], thread_id[7:0]                  | valid/ready
// rsp     | out | status[3:0], next_owner[7:0], hold_count[14:0] | valid/ready
//
// Each request passes two steps: one takes it in and reads the oldest waiter from the
// queue memory, one decides and loads the result register (the registered read sets this).
// Reset clears the owner, the hold count, the queue pointers and fill, and the result
// valid flag; the queue memory and the result payload are left as they are.
// A stalled rsp holds the decision cycle; a new request may be taken while an
// earlier result still waits on rsp.
module recursive_mutex_fifo_handoff #(
	parameter int THREAD_BITS = rmfh_pkg::THREAD_BITS_DEF,
	parameter int QUEUE_DEPTH = rmfh_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS  = rmfh_pkg::COUNT_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rmfh_req_if.sink  req,
	rmfh_rsp_if.source rsp
);
	import rmfh_pkg::*;

	// Commands and status between controller and datapath
	rmfh_cmd_t  cmd;
	rmfh_stat_t stat;

	// Sequence each item: accept, then decide once the result register is free or being emptied
	rmfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the lock state, the waiter queue and the result register
	rmfh_dpath #(
		.THREAD_BITS (THREAD_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.COUNT_BITS  (COUNT_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (req.op),
		.thread_id  (req.thread_id),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.status     (rsp.status),
		.next_owner (rsp.next_owner),
		.hold_count (rsp.hold_count)
	);

endmodule
